@@ design/priority_bitmap_ready_list_defines.svh @@
// ----------------------------------------------------------------------------
// Priority bitmap ready list - assertion macros
// Shared concurrent assertion helpers, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BITMAP_READY_LIST_DEFINES_SVH
`define PRIORITY_BITMAP_READY_LIST_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PBRL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition at one edge that implies a consequence at the next edge.
`define PBRL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/pbrl_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority bitmap ready list - package
// Sizes, command codes and the lowest-set-bit helper for the ready list.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrl_pkg;

   localparam int NUM_PRIORITIES = 64;
   localparam int HANDLE_BITS    = 16;
   localparam int PRIO_BITS      = 6;
   localparam int GROUP_SIZE     = 8;
   localparam int NUM_GROUPS     = 8;
   localparam int POS_BITS       = 3;
   localparam int SLOT_ADDR_BITS = $clog2(NUM_PRIORITIES);

   localparam logic [PRIO_BITS-1:0] IDLE_PRIORITY_RESET = 6'd63;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef logic [NUM_GROUPS-1:0][GROUP_SIZE-1:0] bitmap_type;

   // Position of the lowest set bit; zero when no bit is set.
   function automatic logic [POS_BITS-1:0] lowest_bit(input logic [GROUP_SIZE-1:0] v);
      logic [POS_BITS-1:0] pos;
      pos = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = POS_BITS'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ design/pbrl_ram.sv @@
// ----------------------------------------------------------------------------
// Priority bitmap ready list - generic RAM
// One write port and one read port with registered, read-first read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ design/priority_bitmap_ready_list.sv @@
// ----------------------------------------------------------------------------
// Priority bitmap ready list
// Task-handle store per priority with a two-level ready bitmap and encoder.
// ----------------------------------------------------------------------------
// The block takes one add or remove command per clock cycle while the result
// channel does not stall, and returns exactly one result transfer per command,
// presented in the cycle after the command transfer. The handle store is a
// 64-entry RAM whose registered read port is the result register; a stalled
// result holds the input off only until it is taken.
// Each result carries the handle removed (zero for an add) and the most
// urgent ready priority after the command. Reset empties the list at once:
// a valid bit per slot makes a never-written slot read as an empty handle,
// so no clearing pass is needed. The idle priority register may be written
// at any time the block is idle; a remove at that priority only reports the
// stored handle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_bitmap_ready_list_defines.svh"

module priority_bitmap_ready_list
   import pbrl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Command channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [5:0] priority_req, [21:6] task_handle, zeros above
   input  wire logic        req_tuser,   // [0] cmd (0 add, 1 remove)
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // [15:0] removed_handle, [16] any_ready,
                                         // [22:17] highest_ready, zero above
   // Configuration port for the idle priority register.
   input  wire logic        csr_wen,
   input  wire logic [5:0]  csr_wdata
);

   // Command fields.
   logic                      req_fire;
   logic                      req_cmd;
   logic [PRIO_BITS-1:0]      req_prio;
   logic [HANDLE_BITS-1:0]    req_handle;
   logic [SLOT_ADDR_BITS-1:0] req_addr;
   logic [POS_BITS-1:0]       req_group;
   logic [POS_BITS-1:0]       req_pos;
   logic                      req_in_range;

   // Ready list state.
   logic [PRIO_BITS-1:0]      idle_prio_ff;
   logic [NUM_PRIORITIES-1:0] slot_valid_ff;
   bitmap_type                group_ready_ff;
   bitmap_type                group_ready_in;
   logic [NUM_GROUPS-1:0]     summary_ff;
   logic [NUM_GROUPS-1:0]     summary_in;
   logic [NUM_GROUPS-1:0]     group_nonzero;

   // Handle store write side.
   logic                      ram_wr_en;
   logic [HANDLE_BITS-1:0]    ram_wr_data;
   logic [HANDLE_BITS-1:0]    ram_rd_data;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic                      rsp_hit_in;
   logic                      rsp_any_ff;
   logic                      rsp_any_in;
   logic [PRIO_BITS-1:0]      rsp_highest_ff;
   logic [PRIO_BITS-1:0]      rsp_highest_in;
   logic [POS_BITS-1:0]       enc_group;

   // A new command may enter whenever the result register is empty or is
   // being emptied in this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign req_cmd      = req_tuser;
   assign req_prio     = req_tdata[PRIO_BITS-1:0];
   assign req_handle   = req_tdata[PRIO_BITS +: HANDLE_BITS];
   assign req_addr     = req_prio[SLOT_ADDR_BITS-1:0];
   assign req_group    = req_prio[PRIO_BITS-1 -: POS_BITS];
   assign req_pos      = req_prio[POS_BITS-1:0];
   assign req_in_range = ({1'b0, req_prio} < (PRIO_BITS + 1)'(NUM_PRIORITIES));

   // Bitmap update and handle store write for the accepted command. A remove
   // at the idle priority only reads the slot.
   always_comb begin
      group_ready_in = group_ready_ff;
      summary_in     = summary_ff;
      ram_wr_en      = 1'b0;
      ram_wr_data    = req_handle;
      rsp_hit_in     = 1'b0;
      if (req_fire && req_in_range) begin
         priority if (req_cmd == CMD_ADD) begin
            group_ready_in[req_group][req_pos] = 1'b1;
            summary_in[req_group]              = 1'b1;
            ram_wr_en                          = 1'b1;
         end else if (req_prio != idle_prio_ff) begin
            group_ready_in[req_group][req_pos] = 1'b0;
            if (group_ready_in[req_group] == '0) begin
               summary_in[req_group] = 1'b0;
            end
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            rsp_hit_in  = slot_valid_ff[req_addr];
         end else begin
            rsp_hit_in = slot_valid_ff[req_addr];
         end
      end
   end

   // Two-level encode of the state after the command: first the most urgent
   // group, then the most urgent priority inside it.
   always_comb begin
      enc_group      = lowest_bit(summary_in);
      rsp_any_in     = |summary_in;
      rsp_highest_in = rsp_any_in ? {enc_group, lowest_bit(group_ready_in[enc_group])} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_prio_ff   <= IDLE_PRIORITY_RESET;
         slot_valid_ff  <= '0;
         group_ready_ff <= '0;
         summary_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            idle_prio_ff <= csr_wdata;
         end
         if (ram_wr_en) begin
            slot_valid_ff[req_addr] <= 1'b1;
         end
         group_ready_ff <= group_ready_in;
         summary_ff     <= summary_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; it loads together with the RAM read data.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_hit_ff     <= rsp_hit_in;
         rsp_any_ff     <= rsp_any_in;
         rsp_highest_ff <= rsp_highest_in;
      end
   end

   // The slot read happens on every accepted command, so the read data
   // register serves as the removed-handle part of the result register.
   pbrl_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (NUM_PRIORITIES)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_highest_ff, rsp_any_ff,
                        (rsp_hit_ff ? ram_rd_data : {HANDLE_BITS{1'b0}})};

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_nonzero[g] = |group_ready_ff[g];
      end
   end

   // The group summary always mirrors which groups hold a ready priority.
   `PBRL_ASSERT_ALWAYS(a_summary_matches, summary_ff == group_nonzero,
      "group summary out of step with group ready bits")

   // An empty list reports priority zero.
   `PBRL_ASSERT_ALWAYS(a_empty_reports_zero,
      !rsp_valid_ff || rsp_any_ff || (rsp_highest_ff == '0),
      "empty ready list reported a nonzero priority")

   // A remove at the idle priority leaves the ready state as it was.
   `PBRL_ASSERT_NEXT(a_idle_remove_stable,
      req_fire && (req_cmd == CMD_REMOVE) && (req_prio == idle_prio_ff),
      (group_ready_ff == $past(group_ready_ff)) && (summary_ff == $past(summary_ff)),
      "remove at the idle priority changed the ready state")

   // An add makes its priority ready and its group visible.
   `PBRL_ASSERT_NEXT(a_add_sets_ready,
      req_fire && (req_cmd == CMD_ADD) && req_in_range,
      group_ready_ff[$past(req_group)][$past(req_pos)] && summary_ff[$past(req_group)],
      "add did not mark its priority ready")

endmodule

`default_nettype wire
